>>> src/ppb_pkg.sv
// Shared types, constants and helpers for the projection profile bounds block.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package ppb_pkg;

    localparam int DEF_MAX_BINS = 2048;

    localparam int CNT_IN_W  = 12;
    localparam int GROUP_W   = 5;
    localparam int THRESH_W  = 12;
    localparam int ACC_W     = 16;
    localparam int TOTAL_W   = 22;
    localparam int POS_OUT_W = 11;
    localparam int RHS_W     = TOTAL_W + THRESH_W;

    localparam logic [GROUP_W-1:0]   GROUP_RST  = 5'd10;
    localparam logic [THRESH_W-1:0]  THRESH_RST = 12'd256;
    localparam logic [POS_OUT_W-1:0] POS_MAX    = 11'd2047;

    // register map, decoded on paddr[2]
    localparam logic REG_GROUP     = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [CNT_IN_W-1:0] line_count;
        logic                last_line;
    } ppb_in_t;

    typedef struct packed {
        logic [POS_OUT_W-1:0] lower_bound;
        logic [POS_OUT_W-1:0] upper_bound;
        logic                 bound_found;
    } ppb_out_t;

    typedef struct packed {
        logic accept;
        logic prep;
        logic scan;
        logic finish;
    } ppb_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } ppb_status_t;

    // zero acts as one, anything above 16 as 16
    function automatic logic [GROUP_W-1:0] group_size(input logic [GROUP_W-1:0] g);
        logic [GROUP_W-1:0] r;
        r = g;
        if (g == '0)
            r = 5'd1;
        else if (g > 5'd16)
            r = 5'd16;
        return r;
    endfunction

endpackage

>>> src/ppb_ctrl.sv
// Sequencer for the projection profile bounds block: streaming, scan, result.
// Depends on ppb_pkg.
`timescale 1ns / 1ps

module ppb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                last_line,
    input  ppb_pkg::ppb_status_t status,
    output ppb_pkg::ppb_cmd_t    cmd,
    output logic                in_stall
);
    import ppb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PREP   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_CENTRE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && last_line)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                    state_next = S_CENTRE;
            end
            S_CENTRE:
            begin
                // wait for the output register to free up
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> src/ppb_datapath.sv
// Datapath: bin accumulation, bin memory, threshold scan and centre positions.
// Depends on ppb_pkg.
`timescale 1ns / 1ps

module ppb_datapath #(
    parameter int MAX_BINS = ppb_pkg::DEF_MAX_BINS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ppb_pkg::ppb_in_t               in_data,
    input  ppb_pkg::ppb_cmd_t              cmd,
    input  logic [ppb_pkg::GROUP_W-1:0]    group,
    input  logic [ppb_pkg::THRESH_W-1:0]   threshold,
    input  logic                           out_stall,
    output logic                           out_valid,
    output ppb_pkg::ppb_out_t              out_data,
    output ppb_pkg::ppb_status_t           status
);
    import ppb_pkg::*;

    localparam int IDX_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W  = $clog2(MAX_BINS + 1);
    localparam int PROD_W = ACC_W + CNT_W;
    localparam int CMP_W  = (PROD_W + 8 > RHS_W) ? PROD_W + 8 : RHS_W;
    localparam int POS_W  = (IDX_W + GROUP_W + 1 > POS_OUT_W + 1) ?
                            IDX_W + GROUP_W + 1 : POS_OUT_W + 1;

    logic [ACC_W-1:0]   mem [MAX_BINS];

    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [GROUP_W-1:0] lines_reg, lines_next;
    logic [CNT_W-1:0]   bins_reg, bins_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    logic [ACC_W:0]     acc_sum;
    logic [ACC_W-1:0]   acc_sat;
    logic [GROUP_W-1:0] lines_p1;
    logic               close_bin;
    logic               bins_full;
    logic               wr_en;
    logic [TOTAL_W:0]   total_sum;

    // scan pipeline
    logic [CNT_W-1:0]   rd_cnt_reg;
    logic               issue_done;
    logic               issue;
    logic               v1_reg, v2_reg;
    logic [IDX_W-1:0]   idx1_reg, idx2_reg;
    logic [ACC_W-1:0]   rdata_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [RHS_W-1:0]   rhs_reg;
    logic               above;
    logic               found_reg;
    logic [IDX_W-1:0]   lo_reg, hi_reg;

    logic [POS_W-1:0]     lo_pos, hi_pos;
    logic [POS_OUT_W-1:0] lo_sat, hi_sat;
    logic                 out_valid_reg;
    ppb_out_t             out_data_reg;

    // accumulation of one line word
    always_comb
    begin
        acc_sum   = {1'b0, acc_reg} + (ACC_W + 1)'(in_data.line_count);
        acc_sat   = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
        lines_p1  = lines_reg + 1'b1;
        close_bin = (lines_p1 >= group);
        bins_full = (bins_reg == CNT_W'(MAX_BINS));
        wr_en     = cmd.accept && close_bin && !bins_full;
        total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(acc_sat);

        acc_next   = acc_reg;
        lines_next = lines_reg;
        bins_next  = bins_reg;
        total_next = total_reg;
        if (cmd.accept)
        begin
            if (close_bin)
            begin
                acc_next   = '0;
                lines_next = '0;
                if (!bins_full)
                begin
                    bins_next  = bins_reg + 1'b1;
                    total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                end
            end
            else
            begin
                acc_next   = acc_sat;
                lines_next = lines_p1;
            end
        end
        else if (cmd.finish)
        begin
            acc_next   = '0;
            lines_next = '0;
            bins_next  = '0;
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            lines_reg <= '0;
            bins_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            lines_reg <= lines_next;
            bins_reg  <= bins_next;
            total_reg <= total_next;
        end
    end

    assign issue_done = (rd_cnt_reg == bins_reg);
    assign issue      = cmd.scan && !issue_done;

    // bin memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[bins_reg[IDX_W-1:0]] <= acc_sat;
        if (issue)
            rdata_reg <= mem[rd_cnt_reg[IDX_W-1:0]];
    end

    // bin * bins * 256 > total * threshold
    assign above = (CMP_W'({prod_reg, 8'h00}) > CMP_W'(rhs_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            found_reg  <= 1'b0;
        end
        else if (cmd.prep)
        begin
            rd_cnt_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (issue)
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (v2_reg && above)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
            rhs_reg <= RHS_W'(total_reg) * RHS_W'(threshold);
        idx1_reg <= rd_cnt_reg[IDX_W-1:0];
        idx2_reg <= idx1_reg;
        prod_reg <= PROD_W'(rdata_reg) * PROD_W'(bins_reg);
        if (v2_reg && above)
        begin
            if (!found_reg)
                lo_reg <= idx2_reg;
            hi_reg <= idx2_reg;
        end
    end

    // centre = idx * group + group / 2, saturated
    always_comb
    begin
        lo_pos = POS_W'(lo_reg) * POS_W'(group) + POS_W'(group >> 1);
        hi_pos = POS_W'(hi_reg) * POS_W'(group) + POS_W'(group >> 1);
        lo_sat = (lo_pos > POS_W'(POS_MAX)) ? POS_MAX : lo_pos[POS_OUT_W-1:0];
        hi_sat = (hi_pos > POS_W'(POS_MAX)) ? POS_MAX : hi_pos[POS_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg.lower_bound <= found_reg ? lo_sat : '0;
            out_data_reg.upper_bound <= found_reg ? hi_sat : '0;
            out_data_reg.bound_found <= found_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;
    assign status.scan_done = issue_done && !v1_reg && !v2_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

endmodule

>>> src/projection_profile_bounds.sv
// Top level of the projection profile bounds block: register port, sequencer
// and datapath. Depends on ppb_pkg, ppb_ctrl and ppb_datapath.
`timescale 1ns / 1ps

//  channel  | handshake          | word
//  ---------+--------------------+------------------------------------------
//  in       | in_valid/in_stall  | ppb_in_t  {line_count, last_line}
//  out      | out_valid/out_stall| ppb_out_t {lower_bound, upper_bound, found}
//  config   | APB write/read     | group size @0x0, threshold @0x4
//
// Line words are taken one per cycle while in_stall is low. A word with last_line
// set closes the input through the prep, scan and result states: the scan reads
// the bin memory once per cycle through a two-stage read/multiply pipeline.
// The input stays closed longer while an earlier result still waits.
// The bin memory has no reset; only bins written for the current image are read.
// The result is held in an output register; new line words are taken meanwhile.

module projection_profile_bounds #(
    parameter int MAX_BINS = ppb_pkg::DEF_MAX_BINS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ppb_pkg::ppb_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output ppb_pkg::ppb_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ppb_pkg::*;

    logic [GROUP_W-1:0]  group_reg;
    logic [THRESH_W-1:0] thresh_reg;
    logic                cfg_wr;
    ppb_cmd_t            cmd;
    ppb_status_t         status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg  <= GROUP_RST;
            thresh_reg <= THRESH_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_GROUP)
                group_reg <= pwdata[GROUP_W-1:0];
            else
                thresh_reg <= pwdata[THRESH_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_THRESHOLD)
            prdata = {{(32 - THRESH_W){1'b0}}, thresh_reg};
        else
            prdata = {{(32 - GROUP_W){1'b0}}, group_reg};
    end

    ppb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last_line(in_data.last_line),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    ppb_datapath #(
        .MAX_BINS(MAX_BINS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .group    (group_size(group_reg)),
        .threshold(thresh_reg),
        .out_stall(out_stall),
        .out_valid(out_valid),
        .out_data (out_data),
        .status   (status)
    );

    // a last-line word starts the scan, which closes the input
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.last_line) |=> in_stall)
        else $error("input not stalled after last line word");

    // an ordinary line word keeps the input open
    a_line_open: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !in_data.last_line) |=> !in_stall)
        else $error("input stalled after ordinary line word");

    // results are only loaded at the end of a scan, with the input closed
    a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> $past(in_stall))
        else $error("result produced outside a scan");

endmodule
